[design/pal_pkg.sv]
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } pal_cmd_t;

endpackage

[design/pal_ctrl.sv]
module pal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pal_pkg::pal_cmd_t cmd
);
  import pal_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // result register frees up in the same cycle it is taken
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign cmd.exec  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EMPTY: begin
        if (cmd.exec) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (cmd.exec) state_nxt = S_HOLD;
        else if (out_ready) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_exec_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("accepted item did not produce a result");

  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("new item taken while result stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !cmd.exec) |=> !out_valid)
    else $error("result repeated after transfer");

endmodule

[design/pal_dpath.sv]
module pal_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pal_pkg::pal_cmd_t           cmd,
  input  logic [pal_pkg::ACT_W-1:0]   action,
  input  logic [pal_pkg::POS_W-1:0]   position,
  input  logic [pal_pkg::WORD_W-1:0]  value,
  output logic [pal_pkg::STAT_W-1:0]  res_status,
  output logic [pal_pkg::WORD_W-1:0]  res_read_value,
  output logic [pal_pkg::CNT_W-1:0]   res_length
);
  import pal_pkg::*;

  logic [WORD_W-1:0] cells_r [CAPACITY];
  logic [WORD_W-1:0] cells_nxt [CAPACITY];
  logic [WORD_W-1:0] up_w [CAPACITY];
  logic [WORD_W-1:0] dn_w [CAPACITY];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic [WORD_W-1:0] rd_r;
  logic [WORD_W-1:0] rd_nxt;
  logic              pos_le_cnt;
  logic              pos_lt_cnt;

  // neighbor taps of each cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign up_w[g] = cells_r[g];
    end else begin : g_rest
      assign up_w[g] = cells_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_w[g] = cells_r[g];
    end else begin : g_lower
      assign dn_w[g] = cells_r[g+1];
    end
  end

  assign pos_le_cnt = CNT_W'(position) <= cnt_r;
  assign pos_lt_cnt = CNT_W'(position) < cnt_r;

  always_comb begin
    cells_nxt  = cells_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    case (action_t'(action))
      ACT_INSERT: begin
        if (!pos_le_cnt) begin
          status_nxt = ST_BAD_POS;
        end else if (cnt_r >= CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == CNT_W'(position)) begin
              cells_nxt[i] = value;
            end else if (CNT_W'(i) > CNT_W'(position) && CNT_W'(i) <= cnt_r) begin
              cells_nxt[i] = up_w[i];
            end
          end
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!pos_lt_cnt) begin
          status_nxt = ST_BAD_POS;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) >= CNT_W'(position) && CNT_W'(i + 1) < cnt_r) begin
              cells_nxt[i] = dn_w[i];
            end
          end
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (!pos_lt_cnt) status_nxt = ST_BAD_POS;
        else rd_nxt = cells_r[position[IDX_W-1:0]];
      end
      ACT_CLEAR: begin
        // stored words need no zeroing: nothing past the count is ever read
        cnt_nxt = '0;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) cells_r <= cells_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      status_r <= ST_OK;
      rd_r     <= '0;
    end else if (cmd.exec) begin
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign res_status     = status_r;
  assign res_read_value = rd_r;
  assign res_length     = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == ST_FULL |-> cnt_r == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r != '0 |-> status_r == ST_OK)
    else $error("read value on a failed action");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && action != ACT_CLEAR) |=>
      (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1)
       || cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("count moved by more than one");

endmodule

[design/positional_array_list.sv]
// positional_array_list: ordered list of 32-bit words held in a row of shift cells
// result: registered; shown on out_tvalid in the cycle after the input transfer
// throughput: one item per cycle while out_tready is high; every cell shifts in the same edge, and the
//   result register is refilled in the cycle its previous result is taken
// reset: synchronous on rst_n low; count and output valid clear, stored words are kept
module positional_array_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[4:0], value[36:5], zero fill
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], read_value[33:2], length[38:34], zero fill
);
  import pal_pkg::*;

  pal_cmd_t          cmd;
  logic [STAT_W-1:0] res_status;
  logic [WORD_W-1:0] res_read_value;
  logic [CNT_W-1:0]  res_length;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  pal_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .action         (in_tuser),
    .position       (in_tdata[POS_W-1:0]),
    .value          (in_tdata[POS_W+WORD_W-1:POS_W]),
    .res_status     (res_status),
    .res_read_value (res_read_value),
    .res_length     (res_length)
  );

  assign out_tdata = {{(OUT_W - STAT_W - WORD_W - CNT_W){1'b0}},
                      res_length, res_read_value, res_status};

endmodule
